>>> design/skrs_pkg.sv
// Shared types and constants for the sorted key range search block.
package skrs_pkg;

   localparam int TABLE_DEPTH_DEF     = 1024;
   localparam int LINEAR_CUTOFF_DEF   = 10;
   localparam int ITEM_INDEX_BITS_DEF = 18;

   localparam int KEY_W         = 63;
   localparam int SLOT_FIELD_W  = 10;
   localparam int RANGE_FIELD_W = 11;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BIN_CMP,
      ST_LIN,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic wr;
      logic load;
      logic bin_read;
      logic bin_apply;
      logic lin_init;
      logic lin_step;
      logic take_hit;
      logic emit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic narrow;
      logic key_gt;
      logic key_eq;
      logic mid_at_lo;
      logic lin_hit;
      logic lin_end;
   } dp_status_type;

endpackage

>>> design/skrs_req_if.sv
// Request channel interface: write or search command items.
interface skrs_req_if #(
   parameter int ITEM_INDEX_BITS = skrs_pkg::ITEM_INDEX_BITS_DEF
);
   import skrs_pkg::*;

   logic                       valid;
   logic                       ready;
   cmd_type                    command;
   logic [SLOT_FIELD_W-1:0]    entry_index;
   logic [KEY_W-1:0]           key;
   logic [ITEM_INDEX_BITS-1:0] entry_first;
   logic [ITEM_INDEX_BITS-1:0] entry_last;
   logic [RANGE_FIELD_W-1:0]   range_start;
   logic [RANGE_FIELD_W-1:0]   range_end;

   modport source (
      output valid, command, entry_index, key, entry_first, entry_last,
             range_start, range_end,
      input  ready
   );
   modport sink (
      input  valid, command, entry_index, key, entry_first, entry_last,
             range_start, range_end,
      output ready
   );
endinterface

>>> design/skrs_rsp_if.sv
// Response channel interface: search result items.
interface skrs_rsp_if #(
   parameter int ITEM_INDEX_BITS = skrs_pkg::ITEM_INDEX_BITS_DEF
);
   import skrs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [KEY_W-1:0]           hit_key;
   logic [ITEM_INDEX_BITS-1:0] hit_first;
   logic [ITEM_INDEX_BITS-1:0] hit_last;

   modport source (output valid, found, hit_key, hit_first, hit_last, input ready);
   modport sink   (input  valid, found, hit_key, hit_first, hit_last, output ready);
endinterface

>>> design/skrs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module skrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/skrs_ctrl.sv
// Search sequencer: state machine driving the datapath and the response valid.
module skrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  skrs_pkg::cmd_type      req_command,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output skrs_pkg::ctrl_cmd_type cmd,
   input  skrs_pkg::dp_status_type status
);
   import skrs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_SEARCH) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.empty) state_in = ST_EMIT;
            else if (status.narrow)    state_in = ST_LIN;
            else                       state_in = ST_BIN_CMP;
         end
         ST_BIN_CMP: begin
            priority if (status.key_eq)                   state_in = ST_EMIT;
            else if (status.key_gt)                       state_in = ST_CHECK;
            else if (status.mid_at_lo)                    state_in = ST_EMIT;
            else                                          state_in = ST_CHECK;
         end
         ST_LIN: begin
            if (status.lin_hit || status.lin_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.wr   = accept && (req_command == CMD_WRITE);
            cmd.load = accept && (req_command == CMD_SEARCH);
         end
         ST_CHECK: begin
            cmd.bin_read = !status.empty && !status.narrow;
            cmd.lin_init = !status.empty && status.narrow;
         end
         ST_BIN_CMP: begin
            cmd.take_hit  = status.key_eq;
            cmd.bin_apply = !status.key_eq && (status.key_gt || !status.mid_at_lo);
         end
         ST_LIN: begin
            cmd.take_hit = status.lin_hit;
            cmd.lin_step = !status.lin_hit;
         end
         ST_EMIT: begin
            cmd.emit = slot_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit)  rsp_valid_in = 1'b1;
      else if (rsp_ready)     rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_WRITE) |=> state_ff == ST_IDLE)
      else $error("write command left idle");

   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_SEARCH) |=> state_ff == ST_CHECK)
      else $error("search command did not start");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=>
      (state_ff == ST_EMIT && rsp_valid_ff))
      else $error("result dropped while response stalled");
`endif
endmodule

>>> design/skrs_dp.sv
// Search datapath: table RAM, range bounds, scan pointer and result registers.
module skrs_dp #(
   parameter int TABLE_DEPTH     = skrs_pkg::TABLE_DEPTH_DEF,
   parameter int LINEAR_CUTOFF   = skrs_pkg::LINEAR_CUTOFF_DEF,
   parameter int ITEM_INDEX_BITS = skrs_pkg::ITEM_INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  skrs_pkg::ctrl_cmd_type               cmd,
   output skrs_pkg::dp_status_type              status,
   input  logic [skrs_pkg::SLOT_FIELD_W-1:0]    req_entry_index,
   input  logic [skrs_pkg::KEY_W-1:0]           req_key,
   input  logic [ITEM_INDEX_BITS-1:0]           req_entry_first,
   input  logic [ITEM_INDEX_BITS-1:0]           req_entry_last,
   input  logic [skrs_pkg::RANGE_FIELD_W-1:0]   req_range_start,
   input  logic [skrs_pkg::RANGE_FIELD_W-1:0]   req_range_end,
   output logic                                 rsp_found,
   output logic [skrs_pkg::KEY_W-1:0]           rsp_hit_key,
   output logic [ITEM_INDEX_BITS-1:0]           rsp_hit_first,
   output logic [ITEM_INDEX_BITS-1:0]           rsp_hit_last
);
   import skrs_pkg::*;

   localparam int SLOT_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = KEY_W + 2 * ITEM_INDEX_BITS;

   logic [CNT_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, ptr_ff, ptr_in;
   logic [CNT_W-1:0]   span, mid;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               pend_ff, pend_in;
   logic               res_found_ff, res_found_in;
   logic [ENTRY_W-1:0] res_entry_ff, res_entry_in;
   logic               out_found_ff;
   logic [ENTRY_W-1:0] out_entry_ff;
   logic [31:0]        start_ext, end_ext;
   logic [CNT_W-1:0]   start_sat, end_sat;

   logic               wr_en, rd_en;
   logic [SLOT_W-1:0]  wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic               ptr_live;

   // range saturation to the table depth
   assign start_ext = 32'(req_range_start);
   assign end_ext   = 32'(req_range_end);
   assign start_sat = (start_ext > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(start_ext);
   assign end_sat   = (end_ext > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(end_ext);

   assign span     = hi_ff - lo_ff;
   assign mid      = lo_ff + (span >> 1);
   assign rd_key   = rd_data[ENTRY_W-1 -: KEY_W];
   assign ptr_live = ptr_ff < hi_ff;

   assign status.empty     = hi_ff <= lo_ff;
   assign status.narrow    = 32'(span) < LINEAR_CUTOFF;
   assign status.key_gt    = rd_key > key_ff;
   assign status.key_eq    = rd_key == key_ff;
   assign status.mid_at_lo = mid_ff == lo_ff;
   assign status.lin_hit   = pend_ff && (rd_key == key_ff);
   assign status.lin_end   = !ptr_live;

   // table port
   assign wr_en   = cmd.wr && (32'(req_entry_index) < TABLE_DEPTH);
   assign wr_addr = SLOT_W'(req_entry_index);
   assign wr_data = {req_key, req_entry_first, req_entry_last};
   assign rd_en   = cmd.bin_read || (cmd.lin_step && ptr_live);
   assign rd_addr = cmd.bin_read ? mid[SLOT_W-1:0] : ptr_ff[SLOT_W-1:0];

   skrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      ptr_in       = ptr_ff;
      key_in       = key_ff;
      pend_in      = pend_ff;
      res_found_in = res_found_ff;
      res_entry_in = res_entry_ff;
      if (cmd.load) begin
         lo_in        = start_sat;
         hi_in        = end_sat;
         key_in       = req_key;
         res_found_in = 1'b0;
         res_entry_in = '0;
      end
      if (cmd.bin_read) mid_in = mid;
      if (cmd.bin_apply) begin
         if (status.key_gt) hi_in = mid_ff;
         else               lo_in = mid_ff;
      end
      if (cmd.lin_init) begin
         ptr_in  = lo_ff;
         pend_in = 1'b0;
      end
      if (cmd.lin_step) begin
         pend_in = ptr_live;
         if (ptr_live) ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.take_hit) begin
         res_found_in = 1'b1;
         res_entry_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         res_found_ff <= 1'b0;
         out_found_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         res_found_ff <= res_found_in;
         if (cmd.emit) out_found_ff <= res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      ptr_ff       <= ptr_in;
      key_ff       <= key_in;
      res_entry_ff <= res_entry_in;
      if (cmd.emit) out_entry_ff <= res_entry_ff;
   end

   assign rsp_found     = out_found_ff;
   assign rsp_hit_key   = out_entry_ff[ENTRY_W-1 -: KEY_W];
   assign rsp_hit_first = out_entry_ff[2*ITEM_INDEX_BITS-1 -: ITEM_INDEX_BITS];
   assign rsp_hit_last  = out_entry_ff[ITEM_INDEX_BITS-1:0];

`ifndef SYNTH
   a_load_saturated: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (32'(lo_ff) <= TABLE_DEPTH && 32'(hi_ff) <= TABLE_DEPTH))
      else $error("search bounds beyond table");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.bin_read |-> (mid >= lo_ff && mid < hi_ff))
      else $error("middle slot outside the search range");

   a_halving_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.bin_apply |=> (hi_ff - lo_ff) < $past(hi_ff - lo_ff))
      else $error("halving step did not narrow the range");
`endif
endmodule

>>> design/sorted_key_range_search.sv
// Top level of the sorted key range search block.
// Channels: req_chan carries write and search commands, rsp_chan carries
// one result item per search (none per write). Both use valid/ready; an
// item moves on a clock edge where both are high.
// A write stores {key, first, last} at entry_index (ignored past the
// table); writes can stream back to back while no search runs.
// A search clamps its range to the table, halves it while LINEAR_CUTOFF or
// more slots remain, then scans the rest in order, taking the first equal
// key; an equal key at a halving middle ends the search at once. Each
// halving step issues the middle address, then compares the registered RAM
// data, and the scan reads one slot at a time. A 1024-slot range, cutoff
// 10, takes up to 7 halving steps and then scans up to 8 slots. The table
// RAM has a single read port, so each halving step and each scanned slot
// takes its own read.
// One search is in flight at a time; req_ready is low until its result is
// loaded into the output register. A stalled rsp_chan holds the result;
// the block still takes writes, and a further search waits in its result
// step. Not found gives found = 0 and zeroed hit fields.
// Reset (synchronous) clears control state only; the table is not cleared
// and a search must not touch a slot that was never written.
module sorted_key_range_search #(
   parameter int TABLE_DEPTH     = skrs_pkg::TABLE_DEPTH_DEF,
   parameter int LINEAR_CUTOFF   = skrs_pkg::LINEAR_CUTOFF_DEF,
   parameter int ITEM_INDEX_BITS = skrs_pkg::ITEM_INDEX_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   skrs_req_if.sink      req_chan,
   skrs_rsp_if.source    rsp_chan
);
   import skrs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   skrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .cmd         (cmd),
      .status      (status)
   );

   skrs_dp #(
      .TABLE_DEPTH     (TABLE_DEPTH),
      .LINEAR_CUTOFF   (LINEAR_CUTOFF),
      .ITEM_INDEX_BITS (ITEM_INDEX_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_chan.entry_index),
      .req_key         (req_chan.key),
      .req_entry_first (req_chan.entry_first),
      .req_entry_last  (req_chan.entry_last),
      .req_range_start (req_chan.range_start),
      .req_range_end   (req_chan.range_end),
      .rsp_found       (rsp_chan.found),
      .rsp_hit_key     (rsp_chan.hit_key),
      .rsp_hit_first   (rsp_chan.hit_first),
      .rsp_hit_last    (rsp_chan.hit_last)
   );
endmodule
